### hw/rtl/slm_pkg.sv
package slm_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_LINE    = 2'd1,
    OP_EOL     = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLY_MATCHES   = 2'd2;

  // Distance between the two cases of a letter
  localparam logic [8:0] FOLD_DIFF = 9'd32;

  // Result queue geometry
  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 2;

  typedef struct packed {
    opcode_e    opcode;
    logic [6:0] slot;
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic [7:0] match_start;
    logic       whole_line;
  } out_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic       step;
    logic       clear;
    logic       gate;
    logic       fold;
    logic [7:0] feed;
  } cell_ctl_t;

  // Equal, or apart by exactly the fold distance when folding is on
  function automatic logic bytes_match(input logic [7:0] p, input logic [7:0] t,
                                       input logic fold);
    logic [8:0] pe;
    logic [8:0] te;
    logic       eq;
    logic       up;
    logic       dn;
    pe = {1'b0, p};
    te = {1'b0, t};
    eq = (p == t);
    up = ((pe + FOLD_DIFF) == te);
    dn = ((te + FOLD_DIFF) == pe);
    return eq | (fold & (up | dn));
  endfunction

endpackage

### hw/rtl/slm_stream_if.sv
interface slm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/substring_line_matcher_core.sv
// A taken line byte passes through the cell flags and the evaluation stage, then the result queue.
// Throughput: one request per cycle, set by the one-step shift of the cell chain,
// unless a window replay runs or the result queue lacks room. A pattern write or a
// case_fold write while the current line holds bytes stalls input during the window
// replay through the cells. Reset clears flags, counters, modes and the result queue;
// pattern bytes stay undefined until written, and there is no clearing pass.
module substring_line_matcher_core import slm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 128,
  parameter int unsigned LINE_MAX    = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slm_stream_if.sink            in_if,
  slm_stream_if.source          out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned FillW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CntW  = FillW + 1;
  localparam int unsigned PosW  = $clog2(LINE_MAX);
  localparam int unsigned CmpW  = (PosW > 8) ? PosW : 8;

  // Configuration
  logic [7:0] len_q;
  logic       fold_q;
  logic       only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= 8'd1;
      fold_q <= 1'b0;
      only_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_LENGTH: len_q  <= cfg_data_i;
        CFG_CASE_FOLD:      fold_q <= cfg_data_i[0];
        CFG_ONLY_MATCHES:   only_q <= cfg_data_i[0];
        default:            len_q  <= len_q;
      endcase
    end
  end

  // Request decode
  in_t  req;
  logic accept;
  logic is_pat;
  logic is_line;
  logic is_eol;

  assign req     = in_if.data;
  assign accept  = in_if.valid & in_if.ready;
  assign is_pat  = (req.opcode == OP_PATTERN);
  assign is_line = (req.opcode == OP_LINE);
  assign is_eol  = (req.opcode == OP_EOL);

  // Line counters
  logic [FillW-1:0] fill_q;
  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  pos_d;

  always_comb begin
    pos_d = pos_q;
    if (accept && is_eol) begin
      pos_d = '0;
    end else if (accept && is_line && (pos_q != PosW'(LINE_MAX - 1))) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
    end else begin
      pos_q <= pos_d;
      if (accept && is_eol) begin
        fill_q <= '0;
      end else if (accept && is_line && (fill_q != FillW'(PATTERN_MAX))) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Window replay after the pattern or folding changes mid-line
  logic            rs_q;
  logic [IdxW-1:0] rs_cnt_q;
  logic            rs_start;
  logic            rs_gate;

  assign rs_start = (fill_q != '0) &&
                    ((accept && is_pat) || (cfg_we_i && (cfg_idx_i == CFG_CASE_FOLD)));
  assign rs_gate  = ((CntW'(rs_cnt_q) + CntW'(fill_q)) >= CntW'(PATTERN_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q     <= 1'b0;
      rs_cnt_q <= '0;
    end else if (rs_start) begin
      rs_q     <= 1'b1;
      rs_cnt_q <= '0;
    end else if (rs_q) begin
      if (rs_cnt_q == IdxW'(PATTERN_MAX - 1)) begin
        rs_q <= 1'b0;
      end else begin
        rs_cnt_q <= rs_cnt_q + 1'b1;
      end
    end
  end

  // Cell chain
  logic [7:0]             win   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] flags;
  cell_ctl_t              ctl;

  always_comb begin
    ctl.step  = (accept && is_line) || rs_q;
    ctl.clear = accept && is_eol;
    ctl.gate  = rs_q ? rs_gate : 1'b1;
    ctl.fold  = fold_q;
    ctl.feed  = rs_q ? win[PATTERN_MAX-1] : req.char_in;
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] win_prev;
    logic       flag_prev;
    logic       pat_we;

    if (k == 0) begin : g_head
      assign win_prev  = ctl.feed;
      assign flag_prev = 1'b1;
    end else begin : g_body
      assign win_prev  = win[k-1];
      assign flag_prev = flags[k-1];
    end

    assign pat_we = accept && is_pat && (9'(req.slot) == 9'(k));

    slm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .pat_we_i    (pat_we),
      .pat_data_i  (req.char_in),
      .win_prev_i  (win_prev),
      .flag_prev_i (flag_prev),
      .win_o       (win[k]),
      .flag_o      (flags[k])
    );
  end

  // Evaluation stage: one entry per line byte or end of line
  logic            ev_q;
  logic            ev_eol_q;
  logic [PosW-1:0] ev_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else begin
      ev_q <= accept && (is_line || is_eol);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_eol_q <= is_eol;
      ev_pos_q <= pos_d;
    end
  end

  // Pick the flag of the active pattern length
  logic [7:0]      eff_len;
  logic [IdxW-1:0] sel;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] len_ext;
  logic [CmpW-1:0] start;
  logic            hit;
  logic            rep_q;
  logic            push;
  out_t            push_data;

  always_comb begin
    if (len_q == '0) begin
      eff_len = 8'd1;
    end else if (9'(len_q) > 9'(PATTERN_MAX)) begin
      eff_len = 8'(PATTERN_MAX);
    end else begin
      eff_len = len_q;
    end
  end

  assign sel     = IdxW'(eff_len - 8'd1);
  assign pos_ext = CmpW'(ev_pos_q);
  assign len_ext = CmpW'(eff_len);
  assign start   = pos_ext - len_ext;
  assign hit     = flags[sel] && (pos_ext >= len_ext);

  assign push                  = ev_q && !ev_eol_q && hit && (only_q || !rep_q);
  assign push_data.match_start = start[7:0];
  assign push_data.whole_line  = !only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q <= 1'b0;
    end else if (ev_q && ev_eol_q) begin
      rep_q <= 1'b0;
    end else if (ev_q && hit && !only_q) begin
      rep_q <= 1'b1;
    end
  end

  // Result queue
  logic [OQ_CNT_W-1:0] q_cnt;
  logic                q_valid;
  out_t                q_data;

  slm_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_valid & out_if.ready),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_cnt)
  );

  assign out_if.valid = q_valid;
  assign out_if.data  = q_data;

  // Take a request while no window replay runs and the queue has room for everything in flight
  assign in_if.ready = !rs_q &&
                       (({1'b0, q_cnt} + (OQ_CNT_W + 1)'(ev_q)) < (OQ_CNT_W + 1)'(OQ_DEPTH));

endmodule

### hw/rtl/slm_cell.sv
module slm_cell import slm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic       pat_we_i,
  input  logic [7:0] pat_data_i,
  input  logic [7:0] win_prev_i,
  input  logic       flag_prev_i,
  output logic [7:0] win_o,
  output logic       flag_o
);

  logic [7:0] pat_q;
  logic [7:0] win_q;
  logic       flag_q;
  logic       flag_d;
  logic       hit;

  // Hold this cell's pattern byte
  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pat_q <= pat_data_i;
    end
  end

  // Shift the window byte from the neighbor
  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      win_q <= win_prev_i;
    end
  end

  // Extend the neighbor's prefix match by the byte just fed in
  assign hit = bytes_match(pat_q, ctl_i.feed, ctl_i.fold);

  always_comb begin
    flag_d = flag_q;
    if (ctl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctl_i.step) begin
      flag_d = ctl_i.gate & flag_prev_i & hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign win_o  = win_q;
  assign flag_o = flag_q;

endmodule

### hw/rtl/slm_out_queue.sv
module slm_out_queue import slm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  out_t                push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output out_t                data_o,
  output logic [OQ_CNT_W-1:0] count_o
);

  out_t                mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_q;
  logic [OQ_PTR_W-1:0] rd_q;
  logic [OQ_CNT_W-1:0] cnt_q;

  function automatic logic [OQ_PTR_W-1:0] ptr_next(input logic [OQ_PTR_W-1:0] p);
    return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

### hw/rtl/slm_checker.sv
module slm_checker import slm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input opcode_e              in_opcode_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input out_t                 out_data_i,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i
);

  logic has_bytes_q;
  logic in_acc;

  assign in_acc = in_valid_i & in_ready_i;

  // Track whether the current line has received bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_bytes_q <= 1'b0;
    end else if (in_acc && (in_opcode_i == OP_EOL)) begin
      has_bytes_q <= 1'b0;
    end else if (in_acc && (in_opcode_i == OP_LINE)) begin
      has_bytes_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  a_out_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result withdrawn without handshake");

  a_pat_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == OP_PATTERN) && has_bytes_q |=> !in_ready_i)
    else $error("pattern write mid-line did not start window replay");

  a_fold_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_CASE_FOLD) && has_bytes_q |=> !in_ready_i)
    else $error("case fold change mid-line did not start window replay");

endmodule

bind substring_line_matcher_core slm_checker u_slm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_opcode_i (in_if.data.opcode),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);

### tb/sv/tb_top.sv
module tb_top;
  import slm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PATTERN_SLOTS = 128;
  localparam int unsigned LINE_CAP      = 256;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned MAX_IDLE      = 18;
  localparam int unsigned ITEM_TARGET   = 650;
  localparam int unsigned MIN_PHASES    = 14;
  localparam int unsigned SETTLE_CYCLES = PATTERN_SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned REPORT_MAX    = 10;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_FIXED
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    in_t                   req;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  fixed_hit;
    out_t                  fixed_res;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  slm_stream_if #(.T(in_t))  req_if ();
  slm_stream_if #(.T(out_t)) res_if ();

  substring_line_matcher_core #(
    .PATTERN_MAX(PATTERN_SLOTS),
    .LINE_MAX   (LINE_CAP)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (req_if.sink),
    .out_if    (res_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predicted block state
  logic [7:0]  pat_mem [PATTERN_SLOTS];
  bit          pat_ok  [PATTERN_SLOTS];
  logic [7:0]  win_mem [PATTERN_SLOTS];
  int unsigned line_pos;
  bit          line_done;
  logic [7:0]  len_reg;
  bit          fold_reg;
  bit          only_reg;

  out_t        pending_matches[$];
  row_t        plan_rows[$];

  bit          tx_burst;
  bit          rx_burst;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned phase_cnt;
  int unsigned peak_pos;
  int unsigned cycle_cnt;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned eff_len();
    if (len_reg == 8'd0) return 1;
    if (len_reg > PATTERN_SLOTS) return PATTERN_SLOTS;
    return len_reg;
  endfunction

  // Equal, or apart by exactly 32 in either direction when folding
  function automatic bit byte_hit(input logic [7:0] p, input logic [7:0] t);
    int d;
    d = int'(p) - int'(t);
    return (p == t) || (fold_reg && (d == 32 || d == -32));
  endfunction

  // Byte that differs by exactly 32, staying inside 0..255
  function automatic logic [7:0] fold_twin(input logic [7:0] c);
    if (c < 8'd32) return c + 8'd32;
    if (c > 8'd223) return c - 8'd32;
    return ($urandom_range(0, 1) != 0) ? c + 8'd32 : c - 8'd32;
  endfunction

  // Advance the predicted state by one request and compute its match report
  task automatic predict_match(input in_t r, output bit hit, output out_t res);
    int unsigned k;
    int unsigned n;
    bit          full_hit;
    hit = 1'b0;
    res = '0;
    case (r.opcode)
      OP_PATTERN: begin
        pat_mem[r.slot] = r.char_in;
        pat_ok[r.slot]  = 1'b1;
      end
      OP_EOL: begin
        for (k = 0; k < PATTERN_SLOTS; k++) win_mem[k] = 8'd0;
        line_pos  = 0;
        line_done = 1'b0;
      end
      OP_LINE: begin
        for (k = PATTERN_SLOTS - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
        win_mem[0] = r.char_in;
        if (line_pos < LINE_CAP - 1) line_pos++;
        if (line_pos > peak_pos) peak_pos = line_pos;
        n = eff_len();
        if (line_pos >= n) begin
          full_hit = 1'b1;
          for (k = 0; k < n; k++) begin
            if (!byte_hit(pat_mem[k], win_mem[n-1-k])) full_hit = 1'b0;
          end
          if (full_hit && only_reg) begin
            hit             = 1'b1;
            res.match_start = 8'(line_pos - n);
            res.whole_line  = 1'b0;
          end else if (full_hit && !line_done) begin
            line_done       = 1'b1;
            hit             = 1'b1;
            res.match_start = 8'(line_pos - n);
            res.whole_line  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result(input out_t got);
    out_t want;
    if (pending_matches.size() == 0) begin
      note_failure($sformatf("unexpected result start=%0d whole=%0b",
                             got.match_start, got.whole_line));
      return;
    end
    want = pending_matches.pop_front();
    results_seen++;
    if (got.match_start !== want.match_start || got.whole_line !== want.whole_line) begin
      note_failure($sformatf("result mismatch: expected start=%0d whole=%0b, got start=%0d whole=%0b",
                             want.match_start, want.whole_line,
                             got.match_start, got.whole_line));
    end
  endtask

  // Present one request after a random gap and hold it until taken
  task automatic send_req(input in_t r, output bit hit, output out_t res);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predict_match(r, hit, res);
    if (r.opcode != OP_UNUSED) items_sent++;
  endtask

  task automatic issue_request(input opcode_e op, input logic [6:0] slot, input logic [7:0] ch);
    in_t  r;
    bit   hit;
    out_t res;
    r.opcode  = op;
    r.slot    = slot;
    r.char_in = ch;
    send_req(r, hit, res);
    if (hit) pending_matches.push_back(res);
  endtask

  // Hold requests until every predicted result has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_matches.size() != 0);
  endtask

  // Drain, then let any window replay finish before touching registers
  task automatic pause_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LENGTH: len_reg  = val;
      CFG_CASE_FOLD:      fold_reg = val[0];
      CFG_ONLY_MATCHES:   only_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
  endtask

  // Stream one line: pattern copies (folded at random) mixed with filler and noise
  task automatic send_line(input int unsigned llen, input int unsigned embed_odds);
    int unsigned cnt;
    int unsigned j;
    int unsigned n;
    logic [7:0]  c;
    n   = eff_len();
    cnt = 0;
    while (cnt < llen) begin
      if ($urandom_range(0, 24) == 0) issue_request(OP_UNUSED, 7'($urandom), 8'($urandom));
      if ($urandom_range(0, 79) == 0) issue_request(OP_PATTERN, 7'($urandom), 8'($urandom));
      if ($urandom_range(0, 39) == 0) drain_results();
      if ($urandom_range(1, embed_odds) == 1) begin
        for (j = 0; j < n; j++) begin
          c = pat_mem[j];
          if (fold_reg && $urandom_range(0, 1) != 0) c = fold_twin(c);
          issue_request(OP_LINE, 7'($urandom), c);
        end
        cnt += n;
      end else begin
        c = ($urandom_range(0, 1) != 0) ? pat_mem[$urandom_range(0, n - 1)] : 8'($urandom);
        if ($urandom_range(0, 3) == 0) c = fold_twin(c);
        issue_request(OP_LINE, 7'($urandom), c);
        cnt++;
      end
    end
  endtask

  // New settings, a fresh pattern where needed, then a few lines
  task automatic run_phase(input logic [7:0] len_code, input bit fold, input bit only,
                           input int unsigned lines, input int unsigned line_max);
    int unsigned i;
    int unsigned n;
    bit          refill;
    bit          same;
    logic [7:0]  seed_ch;
    pause_idle();
    cfg_write(CFG_PATTERN_LENGTH, len_code);
    cfg_write(CFG_ONLY_MATCHES, {7'd0, only});
    cfg_write(CFG_CASE_FOLD, {7'd0, fold});
    cfg_close();
    phase_cnt++;
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    n        = eff_len();
    refill   = (n <= 16) && ($urandom_range(0, 2) == 0);
    for (i = 0; i < n; i++) begin
      if (!pat_ok[i]) refill = 1'b1;
    end
    if (refill) begin
      same    = ($urandom_range(0, 3) == 0);
      seed_ch = 8'($urandom);
      for (i = 0; i < n; i++) issue_request(OP_PATTERN, 7'(i), same ? seed_ch : 8'($urandom));
    end
    if ($urandom_range(0, 1) != 0) issue_request(OP_EOL, 7'($urandom), 8'($urandom));
    for (i = 0; i < lines; i++) begin
      send_line($urandom_range(0, line_max), 3);
      if ($urandom_range(0, 4) != 0) issue_request(OP_EOL, 7'($urandom), 8'($urandom));
    end
  endtask

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t req_row(input opcode_e op, input logic [6:0] slot,
                                   input logic [7:0] ch);
    row_t r;
    r               = '0;
    r.kind          = ROW_PRED;
    r.req.opcode    = op;
    r.req.slot      = slot;
    r.req.char_in   = ch;
    return r;
  endfunction

  function automatic row_t fixed_row(input opcode_e op, input logic [6:0] slot,
                                     input logic [7:0] ch, input bit hit,
                                     input logic [7:0] start, input bit whole);
    row_t r;
    r                       = req_row(op, slot, ch);
    r.kind                  = ROW_FIXED;
    r.fixed_hit             = hit;
    r.fixed_res.match_start = start;
    r.fixed_res.whole_line  = whole;
    return r;
  endfunction

  // Result side: random stall before each result, with burst stretches
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid && res_if.ready) check_result(res_if.data);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    bit          hit;
    bit          in_cfg;
    bit          fold;
    bit          only;
    out_t        res;
    logic [7:0]  len_code;

    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    res_if.ready <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;

    for (k = 0; k < PATTERN_SLOTS; k++) begin
      win_mem[k] = 8'd0;
      pat_ok[k]  = 1'b0;
    end
    line_pos     = 0;
    line_done    = 1'b0;
    len_reg      = 8'd1;
    fold_reg     = 1'b0;
    only_reg     = 1'b0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    items_sent   = 0;
    results_seen = 0;
    fail_count   = 0;
    phase_cnt    = 0;
    peak_pos     = 0;
    cycle_cnt    = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, first-match-per-line, ignored opcode
    plan_rows.push_back(fixed_row(OP_EOL,     7'd0,   8'h00, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(fixed_row(OP_PATTERN, 7'd0,   8'h61, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(fixed_row(OP_LINE,    7'd0,   8'h61, 1'b1, 8'd0, 1'b1));
    plan_rows.push_back(fixed_row(OP_LINE,    7'd0,   8'h61, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(fixed_row(OP_UNUSED,  7'd127, 8'hFF, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(fixed_row(OP_EOL,     7'd127, 8'hFF, 1'b0, 8'd0, 1'b0));
    // Every match with folding, extreme slot and byte values
    plan_rows.push_back(cfg_row(CFG_ONLY_MATCHES, 8'd1));
    plan_rows.push_back(cfg_row(CFG_CASE_FOLD, 8'd1));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h41));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h62));
    plan_rows.push_back(fixed_row(OP_PATTERN, 7'd127, 8'hFF, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(fixed_row(OP_PATTERN, 7'd0,   8'h00, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(req_row(OP_LINE,      7'd5,   8'h20));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'hE0));
    // Switch to first-match mode mid-line: earlier reports do not suppress it
    plan_rows.push_back(cfg_row(CFG_ONLY_MATCHES, 8'd0));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h00));
    // Length zero behaves as one
    plan_rows.push_back(cfg_row(CFG_PATTERN_LENGTH, 8'd0));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h20));
    plan_rows.push_back(fixed_row(OP_EOL,     7'd0,   8'h00, 1'b0, 8'd0, 1'b0));
    // Two-byte pattern with a byte at 0x80, matched exactly and then with folding
    plan_rows.push_back(cfg_row(CFG_PATTERN_LENGTH, 8'd2));
    plan_rows.push_back(cfg_row(CFG_CASE_FOLD, 8'd0));
    plan_rows.push_back(fixed_row(OP_PATTERN, 7'd1,   8'h80, 1'b0, 8'd0, 1'b0));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h00));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h80));
    plan_rows.push_back(cfg_row(CFG_ONLY_MATCHES, 8'd1));
    plan_rows.push_back(cfg_row(CFG_CASE_FOLD, 8'd1));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h20));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'hA0));
    plan_rows.push_back(req_row(OP_LINE,      7'd0,   8'h7F));
    plan_rows.push_back(fixed_row(OP_EOL,     7'd0,   8'h00, 1'b0, 8'd0, 1'b0));

    // Walk the directed table
    in_cfg = 1'b0;
    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_CFG) begin
        if (!in_cfg) pause_idle();
        in_cfg = 1'b1;
        cfg_write(plan_rows[i].reg_idx, plan_rows[i].reg_val);
      end else begin
        if (in_cfg) cfg_close();
        in_cfg = 1'b0;
        send_req(plan_rows[i].req, hit, res);
        if (plan_rows[i].kind == ROW_FIXED) begin
          if (plan_rows[i].fixed_hit) pending_matches.push_back(plan_rows[i].fixed_res);
        end else if (hit) begin
          pending_matches.push_back(res);
        end
      end
    end
    if (in_cfg) cfg_close();

    // Longest pattern via an out-of-range length, embedded at random in a line
    run_phase(8'd255, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, 0);
    issue_request(OP_EOL, 7'($urandom), 8'($urandom));
    send_line(130, 2);
    issue_request(OP_EOL, 7'($urandom), 8'($urandom));

    // Line long enough to saturate the position, every match reported
    run_phase(8'd2, 1'b0, 1'b1, 0, 0);
    issue_request(OP_EOL, 7'($urandom), 8'($urandom));
    send_line(270, 4);
    issue_request(OP_EOL, 7'($urandom), 8'($urandom));

    // Random settings and lines, mostly short patterns
    while (items_sent < ITEM_TARGET || phase_cnt < MIN_PHASES) begin
      case ($urandom_range(0, 9))
        0:       len_code = 8'd1;
        1:       len_code = 8'd0;
        2:       len_code = 8'd128;
        3:       len_code = 8'($urandom_range(129, 255));
        default: len_code = 8'($urandom_range(2, 5));
      endcase
      fold = 1'($urandom_range(0, 1));
      only = 1'($urandom_range(0, 1));
      run_phase(len_code, fold, only, $urandom_range(2, 6), $urandom_range(4, 24));
    end

    pause_idle();
    if (pending_matches.size() != 0) begin
      note_failure($sformatf("%0d predicted results never arrived", pending_matches.size()));
    end

    $display("Covered %0d requests over %0d register settings, %0d results checked.",
             items_sent, phase_cnt, results_seen);
    $display("Pattern lengths 0..255 incl. 128, folding and every-match modes, position up to %0d.",
             peak_pos);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
